// ----- sv/dct8_pkg.sv -----
// Package for the 8-point forward DCT butterfly core.
// Holds the rotation constants, the fixed widths and the default sample width.
// No dependencies.
package dct8_pkg;

    // Default width of one input sample.
    localparam int SAMPLE_BITS_DEF = 9;

    // Width of one output coefficient.
    localparam int COEF_BITS = 12;

    // Rotation constants are fractions c/65536. They are held as signed values wide
    // enough to stay positive.
    localparam int K_BITS    = 17;
    localparam int FRAC_BITS = 16;

    localparam logic signed [K_BITS-1:0] K_C1S7 = 17'sd64277;
    localparam logic signed [K_BITS-1:0] K_C2S6 = 17'sd60547;
    localparam logic signed [K_BITS-1:0] K_C3S5 = 17'sd54491;
    localparam logic signed [K_BITS-1:0] K_C4S4 = 17'sd46341;
    localparam logic signed [K_BITS-1:0] K_C5S3 = 17'sd36410;
    localparam logic signed [K_BITS-1:0] K_C6S2 = 17'sd25080;
    localparam logic signed [K_BITS-1:0] K_C7S1 = 17'sd12785;

    // Number of register stages from input to output.
    localparam int PIPE_STAGES = 6;

endpackage

// ----- sv/dct8_forward_butterfly_core.sv -----
// Top level of the 8-point forward DCT core: a six-stage butterfly and rotation pipeline.
// It depends on dct8_pkg for the constants and the default widths.
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_ready    i_sample0 .. i_sample7 (SAMPLE_BITS each)
//  output   out        o_out_valid / i_out_ready  o_coef0 .. o_coef7 (12 bits each)
//
// The core takes one beat of eight samples in every cycle while the output beat is not held,
// and returns one beat of eight coefficients for each through its output register.
// Two levels of constant multiplication set the depth. Each multiplier level has a
// register after it, and the butterflies, the rounding and the saturation sit in the
// stages before, between and after them.
// i_rst_n is synchronous and active low. It clears only the stage valid bits; the data
// registers are not reset.
// When the output beat is held, the whole pipeline stops. Every stage keeps its data and
// its valid bit, so no beat is lost or repeated. A pipeline with empty stages keeps
// taking beats until the output register is full and stalled.
module dct8_forward_butterfly_core
    import dct8_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample0,
    input  logic signed [SAMPLE_BITS-1:0] i_sample1,
    input  logic signed [SAMPLE_BITS-1:0] i_sample2,
    input  logic signed [SAMPLE_BITS-1:0] i_sample3,
    input  logic signed [SAMPLE_BITS-1:0] i_sample4,
    input  logic signed [SAMPLE_BITS-1:0] i_sample5,
    input  logic signed [SAMPLE_BITS-1:0] i_sample6,
    input  logic signed [SAMPLE_BITS-1:0] i_sample7,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COEF_BITS-1:0]  o_coef0,
    output logic signed [COEF_BITS-1:0]  o_coef1,
    output logic signed [COEF_BITS-1:0]  o_coef2,
    output logic signed [COEF_BITS-1:0]  o_coef3,
    output logic signed [COEF_BITS-1:0]  o_coef4,
    output logic signed [COEF_BITS-1:0]  o_coef5,
    output logic signed [COEF_BITS-1:0]  o_coef6,
    output logic signed [COEF_BITS-1:0]  o_coef7
);

    // Widths follow from the sample width.
    // AW: first butterfly. EW: four-term sums for coefficients 0 and 4.
    // DW: the other second-level sums and differences.
    localparam int AW   = SAMPLE_BITS + 1;
    localparam int EW   = SAMPLE_BITS + 3;
    localparam int DW   = SAMPLE_BITS + 2;
    localparam int EPW  = EW + K_BITS;       // product of an EW-wide term
    localparam int DPW  = DW + K_BITS;       // product of a DW-wide term
    localparam int DPW1 = DPW + 1;           // sum of two such products
    localparam int CW   = DPW - FRAC_BITS;   // shared cos(pi/4) term after floor
    localparam int OW   = CW + 2;            // odd rotation inputs
    localparam int QW   = OW + K_BITS;       // product of an odd rotation input
    localparam int QW1  = QW + 1;            // sum of two such products
    localparam int SATW = QW1 - FRAC_BITS;   // widest value that is saturated

    localparam logic signed [SATW-1:0] SAT_HI = SATW'((1 << (COEF_BITS - 1)) - 1);
    localparam logic signed [SATW-1:0] SAT_LO = SATW'(-(1 << (COEF_BITS - 1)));

    function automatic logic signed [COEF_BITS-1:0] sat_coef(
        input logic signed [SATW-1:0] v
    );
        logic signed [SATW-1:0] c;
        begin
            c = v;
            if (v > SAT_HI) begin
                c = SAT_HI;
            end else if (v < SAT_LO) begin
                c = SAT_LO;
            end
            return COEF_BITS'(c);
        end
    endfunction

    // Pipeline control: one shared advance for every stage.
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic                   w_adv;

    assign w_adv      = !r_vld[PIPE_STAGES-1] || i_out_ready;
    assign o_in_ready = w_adv;
    assign n_vld      = {r_vld[PIPE_STAGES-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    // Stage 1: sums and differences of sample pairs.
    logic signed [AW-1:0] r_a0, r_a1, r_a2, r_a3, r_a4, r_a5, r_a6, r_a7;
    logic signed [AW-1:0] n_a0, n_a1, n_a2, n_a3, n_a4, n_a5, n_a6, n_a7;

    always_comb begin
        n_a0 = AW'(i_sample0) + AW'(i_sample7);
        n_a1 = AW'(i_sample1) + AW'(i_sample2);
        n_a2 = AW'(i_sample3) + AW'(i_sample4);
        n_a3 = AW'(i_sample5) + AW'(i_sample6);
        n_a4 = AW'(i_sample5) - AW'(i_sample6);
        n_a5 = AW'(i_sample3) - AW'(i_sample4);
        n_a6 = AW'(i_sample1) - AW'(i_sample2);
        n_a7 = AW'(i_sample0) - AW'(i_sample7);
    end

    // Stage 2: second butterfly level and the inputs of the first multiplier level.
    logic signed [EW-1:0] r_e0, r_e4, n_e0, n_e4;
    logic signed [DW-1:0] r_u2, r_v2, r_d3, r_d4, n_u2, n_v2, n_d3, n_d4;
    logic signed [AW-1:0] r_a5_s2, r_a7_s2;

    always_comb begin
        n_e0 = (EW'(r_a0) + EW'(r_a2)) + (EW'(r_a1) + EW'(r_a3));
        n_e4 = (EW'(r_a0) + EW'(r_a2)) - (EW'(r_a1) + EW'(r_a3));
        n_u2 = DW'(r_a0) - DW'(r_a2);
        n_v2 = DW'(r_a6) - DW'(r_a4);
        n_d3 = DW'(r_a1) - DW'(r_a3);
        n_d4 = DW'(r_a6) + DW'(r_a4);
    end

    // Stage 3: first multiplier level. One product per register.
    logic signed [EPW-1:0] r_p0, r_p4, n_p0, n_p4;
    logic signed [DPW-1:0] r_p2a, r_p2b, r_p6a, r_p6b, r_pc3, r_pc4;
    logic signed [DPW-1:0] n_p2a, n_p2b, n_p6a, n_p6b, n_pc3, n_pc4;
    logic signed [AW-1:0]  r_a5_s3, r_a7_s3;

    always_comb begin
        n_p0  = EPW'(r_e0) * EPW'(K_C4S4);
        n_p4  = EPW'(r_e4) * EPW'(K_C4S4);
        n_p2a = DPW'(r_u2) * DPW'(K_C2S6);
        n_p2b = DPW'(r_v2) * DPW'(K_C6S2);
        n_p6a = DPW'(r_u2) * DPW'(K_C6S2);
        n_p6b = DPW'(r_v2) * DPW'(K_C2S6);
        n_pc3 = DPW'(r_d3) * DPW'(K_C4S4);
        n_pc4 = DPW'(r_d4) * DPW'(K_C4S4);
    end

    // Stage 4: the even coefficients are floored and saturated. The shared
    // cos(pi/4) terms feed the butterflies for the odd rotations.
    logic signed [COEF_BITS-1:0] r_y0, r_y2, r_y4, r_y6, n_y0, n_y2, n_y4, n_y6;
    logic signed [OW-1:0]        r_u1, r_v1, r_u3, r_v3, n_u1, n_v1, n_u3, n_v3;
    logic signed [DPW1-1:0]      w_s2, w_s6, w_c4neg;
    logic signed [CW-1:0]        w_c3;
    logic signed [CW:0]          w_c4;

    always_comb begin
        w_s2    = DPW1'(r_p2a) + DPW1'(r_p2b);
        w_s6    = DPW1'(r_p6a) - DPW1'(r_p6b);
        w_c4neg = -DPW1'(r_pc4);
        // Taking the upper bits of a two's complement value floors it.
        w_c3    = $signed(r_pc3[DPW-1:FRAC_BITS]);
        w_c4    = $signed(w_c4neg[DPW1-1:FRAC_BITS]);
        n_y0    = sat_coef(SATW'($signed(r_p0[EPW-1:FRAC_BITS])));
        n_y4    = sat_coef(SATW'($signed(r_p4[EPW-1:FRAC_BITS])));
        n_y2    = sat_coef(SATW'($signed(w_s2[DPW1-1:FRAC_BITS])));
        n_y6    = sat_coef(SATW'($signed(w_s6[DPW1-1:FRAC_BITS])));
        n_u1    = OW'(r_a7_s3) + OW'(w_c3);
        n_v1    = OW'(w_c4) - OW'(r_a5_s3);
        n_u3    = OW'(r_a7_s3) - OW'(w_c3);
        n_v3    = OW'(w_c4) + OW'(r_a5_s3);
    end

    // Stage 5: second multiplier level for the odd rotations.
    logic signed [QW-1:0] r_q1a, r_q1b, r_q7a, r_q7b, r_q3a, r_q3b, r_q5a, r_q5b;
    logic signed [QW-1:0] n_q1a, n_q1b, n_q7a, n_q7b, n_q3a, n_q3b, n_q5a, n_q5b;
    logic signed [COEF_BITS-1:0] r_y0_s5, r_y2_s5, r_y4_s5, r_y6_s5;

    always_comb begin
        n_q1a = QW'(r_u1) * QW'(K_C1S7);
        n_q1b = QW'(r_v1) * QW'(K_C7S1);
        n_q7a = QW'(r_u1) * QW'(K_C7S1);
        n_q7b = QW'(r_v1) * QW'(K_C1S7);
        n_q3a = QW'(r_u3) * QW'(K_C3S5);
        n_q3b = QW'(r_v3) * QW'(K_C5S3);
        n_q5a = QW'(r_u3) * QW'(K_C5S3);
        n_q5b = QW'(r_v3) * QW'(K_C3S5);
    end

    // Stage 6: odd coefficients are summed, floored and saturated into the output register.
    logic signed [COEF_BITS-1:0] r_coef0, r_coef1, r_coef2, r_coef3;
    logic signed [COEF_BITS-1:0] r_coef4, r_coef5, r_coef6, r_coef7;
    logic signed [COEF_BITS-1:0] n_coef1, n_coef3, n_coef5, n_coef7;
    logic signed [QW1-1:0]       w_s1, w_s7, w_s3, w_s5;

    always_comb begin
        w_s1    = QW1'(r_q1a) - QW1'(r_q1b);
        w_s7    = QW1'(r_q7a) + QW1'(r_q7b);
        w_s3    = QW1'(r_q3a) - QW1'(r_q3b);
        w_s5    = QW1'(r_q5a) + QW1'(r_q5b);
        n_coef1 = sat_coef($signed(w_s1[QW1-1:FRAC_BITS]));
        n_coef7 = sat_coef($signed(w_s7[QW1-1:FRAC_BITS]));
        n_coef3 = sat_coef($signed(w_s3[QW1-1:FRAC_BITS]));
        n_coef5 = sat_coef($signed(w_s5[QW1-1:FRAC_BITS]));
    end

    // Data registers: no reset, all advance together.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a0    <= n_a0;
            r_a1    <= n_a1;
            r_a2    <= n_a2;
            r_a3    <= n_a3;
            r_a4    <= n_a4;
            r_a5    <= n_a5;
            r_a6    <= n_a6;
            r_a7    <= n_a7;

            r_e0    <= n_e0;
            r_e4    <= n_e4;
            r_u2    <= n_u2;
            r_v2    <= n_v2;
            r_d3    <= n_d3;
            r_d4    <= n_d4;
            r_a5_s2 <= r_a5;
            r_a7_s2 <= r_a7;

            r_p0    <= n_p0;
            r_p4    <= n_p4;
            r_p2a   <= n_p2a;
            r_p2b   <= n_p2b;
            r_p6a   <= n_p6a;
            r_p6b   <= n_p6b;
            r_pc3   <= n_pc3;
            r_pc4   <= n_pc4;
            r_a5_s3 <= r_a5_s2;
            r_a7_s3 <= r_a7_s2;

            r_y0    <= n_y0;
            r_y2    <= n_y2;
            r_y4    <= n_y4;
            r_y6    <= n_y6;
            r_u1    <= n_u1;
            r_v1    <= n_v1;
            r_u3    <= n_u3;
            r_v3    <= n_v3;

            r_q1a   <= n_q1a;
            r_q1b   <= n_q1b;
            r_q7a   <= n_q7a;
            r_q7b   <= n_q7b;
            r_q3a   <= n_q3a;
            r_q3b   <= n_q3b;
            r_q5a   <= n_q5a;
            r_q5b   <= n_q5b;
            r_y0_s5 <= r_y0;
            r_y2_s5 <= r_y2;
            r_y4_s5 <= r_y4;
            r_y6_s5 <= r_y6;

            r_coef0 <= r_y0_s5;
            r_coef2 <= r_y2_s5;
            r_coef4 <= r_y4_s5;
            r_coef6 <= r_y6_s5;
            r_coef1 <= n_coef1;
            r_coef3 <= n_coef3;
            r_coef5 <= n_coef5;
            r_coef7 <= n_coef7;
        end
    end

    assign o_out_valid = r_vld[PIPE_STAGES-1];
    assign o_coef0     = r_coef0;
    assign o_coef1     = r_coef1;
    assign o_coef2     = r_coef2;
    assign o_coef3     = r_coef3;
    assign o_coef4     = r_coef4;
    assign o_coef5     = r_coef5;
    assign o_coef6     = r_coef6;
    assign o_coef7     = r_coef7;

`ifndef SYNTHESIS
    // Each valid bit moves exactly one stage on an advance. No beat is dropped or invented.
    a_vld_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_vld[PIPE_STAGES-1:1] == $past(r_vld[PIPE_STAGES-2:0]))
        else $error("stage valid bits did not shift on advance");

    // An accepted input beat always lands in the first stage.
    a_vld_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_vld[0] == $past(i_in_valid))
        else $error("first stage valid does not match the accepted input");

    // A stall freezes every stage.
    a_vld_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("stage valid bits changed during a stall");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");
`endif

endmodule
